// ===== hdl/chbt_pkg.sv =====
// Shared types, codes and default sizes for the chained hash bucket table.
package chbt_pkg;

    // Default sizes handed to the top level parameters.
    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int NUM_NODES_DEF   = 4096;
    localparam int MAX_MATCHES_DEF = 32;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // Width of the saturating removal and match count.
    localparam int COUNT_W = 13;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_LATCH,
        ST_FETCH,
        ST_CHECK
    } state_t;

    // One command item.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] bucket_hash;
        logic signed [31:0] check_hash;
        logic [15:0]        entry_index;
        logic [5:0]         match_limit;
    } cmd_item_t;

    // One result item.
    typedef struct packed {
        logic [15:0]        match_index;
        logic               match_valid;
        logic [COUNT_W-1:0] match_count;
        logic               status;
        logic               last;
    } res_item_t;

endpackage

// ===== hdl/chbt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module chbt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/chbt_bucket_mod.sv =====
// Bucket selection: the sign-extended hash reduced modulo the bucket count.
module chbt_bucket_mod
#(
    parameter int NUM_BUCKETS = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [31:0]                    hash,
    output logic                           done,
    output logic [$clog2(NUM_BUCKETS)-1:0] bucket
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

    generate
        if (IS_POW2)
        begin : g_mask
            logic          done_reg;
            logic [BW-1:0] bucket_reg;

            // A power of two bucket count registers the low bits, with done in the cycle after start.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bucket_reg <= hash[BW-1:0];
                end
            end

            assign done   = done_reg;
            assign bucket = bucket_reg;
        end
        else
        begin : g_recip
            // Reciprocal of the bucket count scaled by 2^48, and the weight of
            // the sign extension (2^64 - 2^32) reduced by the bucket count.
            localparam longint unsigned RECIP = (64'd1 << 48) / 64'(NUM_BUCKETS);
            localparam longint unsigned P32   = (64'd1 << 32) % 64'(NUM_BUCKETS);
            localparam longint unsigned M32   = 64'hFFFF_FFFF % 64'(NUM_BUCKETS);
            localparam longint unsigned SEXT  = (P32 * M32) % 64'(NUM_BUCKETS);
            localparam logic [15:0] R0   = 16'(RECIP);
            localparam logic [15:0] R1   = 16'(RECIP >> 16);
            localparam logic [15:0] R2   = 16'(RECIP >> 32);
            localparam logic [15:0] NB16 = 16'(NUM_BUCKETS);
            localparam logic [BW:0] NB   = (BW+1)'(NUM_BUCKETS);
            localparam logic [BW:0] SX   = (BW+1)'(SEXT);

            logic          run_reg;
            logic          done_reg;
            logic [2:0]    step_reg;
            logic [31:0]   hash_reg;
            logic [48:0]   acc_reg;
            logic [BW:0]   part_reg;
            logic [BW-1:0] rem_reg;
            logic [31:0]   mul_a;
            logic [15:0]   mul_b;
            logic [47:0]   prod;
            logic [32:0]   diff;
            logic [BW:0]   red1;
            logic [BW:0]   sum;
            logic [BW-1:0] rem_next;

            // One shared 32 by 16 multiplier: three steps form the quotient
            // estimate, a fourth multiplies it back by the bucket count.
            always_comb
            begin
                case (step_reg)
                    3'd0:    mul_b = R0;
                    3'd1:    mul_b = R1;
                    3'd2:    mul_b = R2;
                    default: mul_b = NB16;
                endcase
                mul_a    = (step_reg == 3'd3) ? acc_reg[47:16] : hash_reg;
                prod     = mul_a * mul_b;
                diff     = {1'b0, hash_reg} - prod[32:0];
                red1     = (part_reg >= NB) ? (part_reg - NB) : part_reg;
                sum      = red1 + (hash_reg[31] ? SX : '0);
                rem_next = (sum >= NB) ? BW'(sum - NB) : sum[BW-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        run_reg  <= 1'b1;
                        step_reg <= '0;
                    end
                    else if (run_reg)
                    begin
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd4)
                        begin
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            // The quotient estimate is low by at most one, so the partial
            // remainder is below twice the bucket count.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    hash_reg <= hash;
                end
                else if (run_reg)
                begin
                    case (step_reg) inside
                        3'd0:       acc_reg  <= {1'b0, prod};
                        3'd1, 3'd2: acc_reg  <= {16'd0, acc_reg[48:16]} + 49'(prod);
                        3'd3:       part_reg <= diff[BW:0];
                        default:    rem_reg  <= rem_next;
                    endcase
                end
            end

            assign done   = done_reg;
            assign bucket = rem_reg;
        end
    endgenerate

endmodule

// ===== hdl/chained_hash_bucket_table_top.sv =====
// Top level of the chained hash bucket table: sequencer, datapath and memories.
//
//  channel   | direction | handshake                         | payload
//  command   | in        | start high while busy low         | cmd_item_t
//  result    | out       | result_strobe, one cycle, no hold | res_item_t
//
// After reset a clearing pass writes every bucket head empty, with busy high.
// Bucket selection takes the low hash bits for a power of two bucket count
// and a reduction by reciprocal multiply otherwise. Insert then passes the
// head and latch states, an unused mode ends in the head state. Remove and
// lookup walk the chain: one node RAM read and one compare per node visited.
// Busy drops in the cycle that shows the final result; the receiver cannot
// stall, each result shows for one cycle.
module chained_hash_bucket_table_top
    import chbt_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int NUM_NODES   = NUM_NODES_DEF,
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cmd_item_t command,
    output logic      result_strobe,
    output res_item_t result
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int PW = $clog2(NUM_NODES);
    localparam int LW = PW + 1;
    localparam int NW = 48 + LW;
    localparam int KW = $clog2(MAX_MATCHES + 1);
    localparam logic [LW-1:0] NIL = '1;
    localparam logic [PW:0] NODES = (PW+1)'(NUM_NODES);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    state_t             state_reg, state_next;
    cmd_item_t          cmd_reg;
    logic [BW-1:0]      clr_cnt_reg;
    logic [LW-1:0]      cur_reg, cur_next;
    logic [LW-1:0]      prev_reg, prev_next;
    logic [NW-1:0]      prev_data_reg, prev_data_next;
    logic [PW:0]        steps_reg, steps_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [PW:0]        free_top_reg, free_top_next;
    logic [PW:0]        pool_used_reg, pool_used_next;
    res_item_t          res_reg, res_next;
    logic               strobe_reg, strobe_next;

    logic               accept;
    logic               mod_done;
    logic [BW-1:0]      bucket;

    logic               bk_we;
    logic [BW-1:0]      bk_addr;
    logic [LW-1:0]      bk_wdata, bk_rdata;
    logic               nd_we;
    logic [PW-1:0]      nd_waddr, nd_raddr;
    logic [NW-1:0]      nd_wdata, nd_rdata;
    logic               fs_we;
    logic [PW-1:0]      fs_waddr, fs_raddr;
    logic [PW-1:0]      fs_wdata, fs_rdata;
    logic [PW:0]        ft_dec;

    logic [KW-1:0]      limit;
    logic               walk_stop;
    logic               chk_hit;
    logic               idx_hit;
    logic [LW-1:0]      nxt;
    logic [PW-1:0]      new_node;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Bucket index unit.
    chbt_bucket_mod #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .hash   (command.bucket_hash),
        .done   (mod_done),
        .bucket (bucket)
    );

    // Bucket heads, node words {index, check, next} and the free stack.
    chbt_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_heads
    (
        .clk(clk), .we(bk_we), .waddr(bk_addr), .wdata(bk_wdata),
        .raddr(bucket), .rdata(bk_rdata)
    );

    chbt_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_nodes
    (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata)
    );

    chbt_ram #(.WIDTH(PW), .DEPTH(NUM_NODES)) u_free
    (
        .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rdata)
    );

    // Shared decode of the current item and node.
    always_comb
    begin
        ft_dec    = free_top_reg - (PW+1)'(1);
        fs_raddr  = ft_dec[PW-1:0];
        nd_raddr  = cur_reg[PW-1:0];
        limit     = (cmd_reg.match_limit > 6'(MAX_MATCHES)) ? KW'(MAX_MATCHES)
                                                            : KW'(cmd_reg.match_limit);
        nxt       = nd_rdata[LW-1:0];
        chk_hit   = (nd_rdata[LW+31:LW] == cmd_reg.check_hash);
        idx_hit   = (nd_rdata[NW-1:LW+32] == cmd_reg.entry_index);
        walk_stop = cur_reg[PW] || (steps_reg == NODES) ||
                    ((cmd_reg.mode == MODE_LOOKUP) && (k_reg >= limit));
        new_node  = (free_top_reg != '0) ? fs_rdata : pool_used_reg[PW-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_BUCKET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mod_done)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                case (cmd_reg.mode) inside
                    MODE_INSERT, MODE_REMOVE, MODE_LOOKUP: state_next = ST_LATCH;
                    default:                               state_next = ST_IDLE;
                endcase
            end
            ST_LATCH:
            begin
                state_next = (cmd_reg.mode == MODE_INSERT) ? ST_IDLE : ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = walk_stop ? ST_IDLE : ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_FETCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates, memory writes and results.
    always_comb
    begin
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_data_next = prev_data_reg;
        steps_next     = steps_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        free_top_next  = free_top_reg;
        pool_used_next = pool_used_reg;
        res_next       = '0;
        strobe_next    = 1'b0;
        bk_we          = 1'b0;
        bk_addr        = bucket;
        bk_wdata       = NIL;
        nd_we          = 1'b0;
        nd_waddr       = prev_reg[PW-1:0];
        nd_wdata       = {prev_data_reg[NW-1:LW], nxt};
        fs_we          = 1'b0;
        fs_waddr       = free_top_reg[PW-1:0];
        fs_wdata       = cur_reg[PW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                bk_we   = 1'b1;
                bk_addr = clr_cnt_reg;
            end
            ST_HEAD:
            begin
                // An unused mode answers with a bare final result.
                case (cmd_reg.mode) inside
                    MODE_INSERT, MODE_REMOVE, MODE_LOOKUP: ;
                    default:
                    begin
                        strobe_next   = 1'b1;
                        res_next.last = 1'b1;
                    end
                endcase
            end
            ST_LATCH:
            begin
                if (cmd_reg.mode == MODE_INSERT)
                begin
                    // Take a node, if the pool has one, and link it at the head of the bucket.
                    strobe_next   = 1'b1;
                    res_next.last = 1'b1;
                    if ((free_top_reg != '0) || (pool_used_reg < NODES))
                    begin
                        if (free_top_reg != '0)
                        begin
                            free_top_next = ft_dec;
                        end
                        else
                        begin
                            pool_used_next = pool_used_reg + (PW+1)'(1);
                        end
                        nd_we    = 1'b1;
                        nd_waddr = new_node;
                        nd_wdata = {cmd_reg.entry_index, cmd_reg.check_hash, bk_rdata};
                        bk_we    = 1'b1;
                        bk_wdata = {1'b0, new_node};
                    end
                    else
                    begin
                        res_next.status = 1'b1;
                    end
                end
                else
                begin
                    cur_next   = bk_rdata;
                    prev_next  = NIL;
                    steps_next = '0;
                    count_next = '0;
                    k_next     = '0;
                end
            end
            ST_FETCH:
            begin
                if (walk_stop)
                begin
                    strobe_next   = 1'b1;
                    res_next.last = 1'b1;
                    res_next.match_count = (cmd_reg.mode == MODE_LOOKUP) ?
                                           COUNT_W'(k_reg) : count_reg;
                end
            end
            ST_CHECK:
            begin
                if (cmd_reg.mode == MODE_LOOKUP)
                begin
                    if (chk_hit)
                    begin
                        strobe_next          = 1'b1;
                        res_next.match_valid = 1'b1;
                        res_next.match_index = nd_rdata[NW-1:LW+32];
                        k_next               = k_reg + KW'(1);
                    end
                end
                else if (chk_hit && idx_hit)
                begin
                    // Unlink the node and push it on the free stack.
                    if (free_top_reg < NODES)
                    begin
                        fs_we         = 1'b1;
                        free_top_next = free_top_reg + (PW+1)'(1);
                    end
                    if (prev_reg[PW])
                    begin
                        bk_we    = 1'b1;
                        bk_wdata = nxt;
                    end
                    else
                    begin
                        nd_we = 1'b1;
                    end
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    prev_next      = cur_reg;
                    prev_data_next = nd_rdata;
                end
                cur_next   = nxt;
                steps_next = steps_reg + (PW+1)'(1);
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            free_top_reg  <= '0;
            pool_used_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_top_reg  <= free_top_next;
            pool_used_reg <= pool_used_next;
            strobe_reg    <= strobe_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
        end
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_data_reg <= prev_data_next;
        steps_reg     <= steps_next;
        count_reg     <= count_next;
        k_reg         <= k_next;
        res_reg       <= res_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

// ===== hdl/chbt_checker.sv =====
// Port level checks of the chained hash bucket table, bound to the top level.
module chbt_checker
    import chbt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      result_strobe,
    input res_item_t result
);

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // A match result is never the final one, and the block still works on.
    a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.match_valid) |-> (!result.last && busy))
        else $error("match result marked last or block idle");

    // Match results carry no count and no error.
    a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.match_valid) |->
        (result.match_count == '0 && !result.status))
        else $error("match result carries count or status");

    // A pool full error only appears on a final result without a match.
    a_full_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.status) |->
        (result.last && result.match_count == '0))
        else $error("pool full status on a non-final result");

    // Every result that is not final leaves the block busy.
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> busy)
        else $error("block idle before the final result");

endmodule

bind chained_hash_bucket_table_top chbt_checker u_chbt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);

// ===== test/chained_hash_bucket_table_top_tb.sv =====
// Self-checking testbench for the chained hash bucket table top level.
module chained_hash_bucket_table_top_tb
    import chbt_pkg::*;
();

    localparam int NB    = NUM_BUCKETS_DEF;
    localparam int NN    = NUM_NODES_DEF;
    localparam int MAXM  = MAX_MATCHES_DEF;
    localparam int NIL   = -1;
    localparam int CMAX  = 8191;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Predicts table results and holds the expected result items in order.
    class table_scoreboard;
        int          heads [NB];
        logic [15:0] n_index [NN];
        logic [31:0] n_check [NN];
        int          n_next [NN];
        int          free_list [NN];
        int          free_top;
        int          pool_used;
        res_item_t   pending [$];
        int          errors;

        function new();
            foreach (heads[i])
            begin
                heads[i] = NIL;
            end
            free_top  = 0;
            pool_used = 0;
            errors    = 0;
        endfunction

        function void add_expected(logic [15:0] idx, logic vld, int cnt, logic st, logic lst);
            res_item_t r;
            r.match_index = idx;
            r.match_valid = vld;
            r.match_count = cnt[COUNT_W-1:0];
            r.status      = st;
            r.last        = lst;
            pending = {pending, r};
        endfunction

        // Apply one accepted command item to the shadow table.
        function void note_command(cmd_item_t c);
            int b, cur, prv, nxt, cnt, steps, lim, n;
            b = int'({{32{c.bucket_hash[31]}}, c.bucket_hash} % 64'(NB));
            case (c.mode)
                MODE_INSERT:
                begin
                    if (free_top > 0)
                    begin
                        free_top--;
                        n = free_list[free_top];
                    end
                    else if (pool_used < NN)
                    begin
                        n = pool_used;
                        pool_used++;
                    end
                    else
                    begin
                        add_expected(16'd0, 1'b0, 0, 1'b1, 1'b1);
                        return;
                    end
                    n_index[n] = c.entry_index;
                    n_check[n] = c.check_hash;
                    n_next[n]  = heads[b];
                    heads[b]   = n;
                    add_expected(16'd0, 1'b0, 0, 1'b0, 1'b1);
                end
                MODE_REMOVE:
                begin
                    cnt = 0;
                    prv = NIL;
                    cur = heads[b];
                    steps = 0;
                    while (cur >= 0 && cur < NN && steps < NN)
                    begin
                        nxt = n_next[cur];
                        if (n_check[cur] == c.check_hash && n_index[cur] == c.entry_index)
                        begin
                            if (free_top < NN)
                            begin
                                free_list[free_top] = cur;
                                free_top++;
                            end
                            if (prv == NIL)
                                heads[b] = nxt;
                            else
                                n_next[prv] = nxt;
                            if (cnt < CMAX)
                                cnt++;
                        end
                        else
                        begin
                            prv = cur;
                        end
                        cur = nxt;
                        steps++;
                    end
                    add_expected(16'd0, 1'b0, cnt, 1'b0, 1'b1);
                end
                MODE_LOOKUP:
                begin
                    lim = (c.match_limit > MAXM) ? MAXM : int'(c.match_limit);
                    cnt = 0;
                    cur = heads[b];
                    steps = 0;
                    while (cur >= 0 && cur < NN && steps < NN && cnt < lim)
                    begin
                        if (n_check[cur] == c.check_hash)
                        begin
                            add_expected(n_index[cur], 1'b1, 0, 1'b0, 1'b0);
                            cnt++;
                        end
                        cur = n_next[cur];
                        steps++;
                    end
                    add_expected(16'd0, 1'b0, cnt, 1'b0, 1'b1);
                end
                default:
                begin
                    add_expected(16'd0, 1'b0, 0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        task report_err(string msg);
            errors++;
            if (errors <= 50)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Compare one result item with the oldest expectation.
        task check_result(res_item_t got);
            res_item_t exp_r;
            if (pending.size() == 0)
            begin
                report_err("result item with nothing expected");
                return;
            end
            exp_r = pending.pop_front();
            if (got.match_index !== exp_r.match_index)
                report_err($sformatf("match_index %0d, expected %0d",
                                     got.match_index, exp_r.match_index));
            if (got.match_valid !== exp_r.match_valid)
                report_err($sformatf("match_valid %0b, expected %0b",
                                     got.match_valid, exp_r.match_valid));
            if (got.match_count !== exp_r.match_count)
                report_err($sformatf("match_count %0d, expected %0d",
                                     got.match_count, exp_r.match_count));
            if (got.status !== exp_r.status)
                report_err($sformatf("status %0b, expected %0b", got.status, exp_r.status));
            if (got.last !== exp_r.last)
                report_err($sformatf("last %0b, expected %0b", got.last, exp_r.last));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    cmd_item_t command;
    logic      result_strobe;
    res_item_t result;

    table_scoreboard sb;
    logic [31:0] live_bh [$];
    logic [31:0] live_ch [$];
    logic [15:0] live_ix [$];
    int          burst_left;

    chained_hash_bucket_table_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .result_strobe(result_strobe),
        .result(result)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check each result item at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_result(result);
    end

    // Send one command item; gaps come between random bursts.
    task automatic send_command(input logic [1:0] md, input logic [31:0] bh,
                                input logic [31:0] ch, input logic [15:0] ix,
                                input logic [5:0] lim);
        cmd_item_t c;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        else
        begin
            @(negedge clk);
        end
        burst_left--;
        c.mode        = md;
        c.bucket_hash = bh;
        c.check_hash  = ch;
        c.entry_index = ix;
        c.match_limit = lim;
        command <= c;
        start   <= 1'b1;
        // Busy is steady from a falling edge to the next rising edge.
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_command(c);
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Insert and remember the key so later removes and lookups find it.
    task automatic insert_key(input logic [31:0] bh, input logic [31:0] ch,
                              input logic [15:0] ix);
        send_command(MODE_INSERT, bh, ch, ix, 6'd0);
        live_bh = {live_bh, bh};
        live_ch = {live_ch, ch};
        live_ix = {live_ix, ix};
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin
        int k, op, p;
        logic [31:0] bh;
        sb = new();
        burst_left = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        command = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, duplicates, every mode and the special cases.
        insert_key(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        insert_key(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
        insert_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555);
        insert_key(32'h0000_0005, 32'h0000_0001, 16'hAAAA);
        insert_key(32'h0000_0005, 32'h0000_0001, 16'hAAAA);
        insert_key(32'h0000_0405, 32'h0000_0001, 16'h1234);
        insert_key(32'h0000_0005, 32'h0000_0002, 16'h0007);
        send_command(MODE_LOOKUP, 32'h0000_0005, 32'h0000_0001, 16'h0, 6'd63);
        send_command(MODE_LOOKUP, 32'h0000_0005, 32'h0000_0001, 16'h0, 6'd1);
        send_command(MODE_LOOKUP, 32'h0000_0005, 32'h0000_0001, 16'h0, 6'd0);
        send_command(MODE_LOOKUP, 32'h0000_0123, 32'h0000_0001, 16'h0, 6'd32);
        // Two adjacent matching nodes exercise the predecessor repair.
        send_command(MODE_REMOVE, 32'h0000_0005, 32'h0000_0001, 16'hAAAA, 6'd0);
        send_command(MODE_LOOKUP, 32'h0000_0005, 32'h0000_0002, 16'h0, 6'd33);
        send_command(MODE_LOOKUP, 32'h0000_0405, 32'h0000_0001, 16'h0, 6'd32);
        send_command(MODE_REMOVE, 32'h0000_0005, 32'h0000_0009, 16'h0007, 6'd0);
        send_command(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F);
        // Reuse nodes from the free stack.
        insert_key(32'h0000_0005, 32'h0000_0001, 16'h0101);
        send_command(MODE_LOOKUP, 32'h0000_0005, 32'h0000_0001, 16'h0, 6'd32);

        // Pause until the table has answered everything.
        wait_drained();

        // Random: mostly live keys in a few crowded buckets, some noise.
        for (k = 0; k < 142; k++)
        begin
            op = $urandom_range(0, 99);
            bh = (($urandom_range(0, 1) != 0) ? ($urandom() & 32'hFFFF_FC00) : 32'h0)
                 | 32'($urandom_range(0, 7));
            if (op < 40)
                insert_key(bh, 32'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
            else if (op < 65 && live_bh.size() > 0)
            begin
                p = $urandom_range(0, live_bh.size() - 1);
                send_command(MODE_LOOKUP, live_bh[p], live_ch[p], 16'h0,
                             6'($urandom_range(0, 63)));
            end
            else if (op < 88 && live_bh.size() > 0)
            begin
                p = $urandom_range(0, live_bh.size() - 1);
                send_command(MODE_REMOVE, live_bh[p], live_ch[p], live_ix[p], 6'd0);
                live_bh.delete(p);
                live_ch.delete(p);
                live_ix.delete(p);
            end
            else if (op < 96)
                send_command(MODE_REMOVE, $urandom(), $urandom(), 16'($urandom()),
                             6'($urandom()));
            else
                send_command(op[0] ? MODE_UNUSED : MODE_LOOKUP, $urandom(), $urandom(),
                             16'($urandom()), 6'($urandom()));
        end

        wait_drained();
        repeat (200) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
